// ===== hw/rtl/lzrd_pkg.sv =====
// ----------------------------------------------------------------------------
// lzrd_pkg
// Shared types and constants for the LZSS ring-buffer decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lzrd_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned BIAS_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned FLAG_W    = 16;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [BIAS_W-1:0]    bias_t;
  typedef logic [LEN_W-1:0]     len_t;
  typedef logic [FLAG_W-1:0]    flag_t;

  localparam cfg_idx_t CFG_FILL_BYTE   = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_LENGTH_BIAS = cfg_idx_t'(1);

  localparam byte_t FILL_BYTE_RST   = 8'd32;
  localparam bias_t LENGTH_BIAS_RST = 2'd2;
  localparam byte_t FLAG_MARK       = 8'hff;

  typedef enum logic [1:0] {
    PH_FLAG  = 2'd0,
    PH_ITEM  = 2'd1,
    PH_MATCH = 2'd2
  } phase_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lzrd_in_if.sv =====
// ----------------------------------------------------------------------------
// lzrd_in_if
// Compressed byte channel: valid/ready with one byte and a stream-start mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface lzrd_in_if;
  logic                  valid;
  logic                  ready;
  lzrd_pkg::byte_t       in_byte;
  logic                  start_of_stream;

  modport source (output valid, in_byte, start_of_stream, input ready);
  modport sink   (input valid, in_byte, start_of_stream, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lzrd_out_if.sv =====
// ----------------------------------------------------------------------------
// lzrd_out_if
// Decompressed byte channel: valid/ready with one byte and an end-of-run mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface lzrd_out_if;
  logic                  valid;
  logic                  ready;
  lzrd_pkg::byte_t       out_byte;
  logic                  last_of_run;

  modport source (output valid, out_byte, last_of_run, input ready);
  modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lzrd_cfg_if.sv =====
// ----------------------------------------------------------------------------
// lzrd_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
`default_nettype none

interface lzrd_cfg_if;
  logic                  valid;
  logic                  ready;
  lzrd_pkg::cfg_idx_t    index;
  lzrd_pkg::byte_t       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lzrd_ram.sv =====
// ----------------------------------------------------------------------------
// lzrd_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lzrd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lzss_ring_buffer_decoder_top.sv =====
// ----------------------------------------------------------------------------
// lzss_ring_buffer_decoder_top
// LZSS decoder with a ring-buffer window in one synchronous RAM.
// ----------------------------------------------------------------------------
// Flag bytes and the first item of a flag group pass accept and decode; later
// items of a group pass accept, flag shift and decode. A literal is presented
// from the output register after decode once the output slot is free; a match
// presents its first byte after decode, ring read and output register, then
// one per cycle while the output is ready. Reset and every start-of-stream
// transaction run a ring fill pass, one entry per cycle, with input held off.
`default_nettype none

module lzss_ring_buffer_decoder_top #(
  parameter int unsigned RING_SIZE  = 4096,
  parameter int unsigned MAX_STRING = 16
) (
  input wire logic   clk,
  input wire logic   rst,
  lzrd_in_if.sink    compressed,
  lzrd_out_if.source decompressed,
  lzrd_cfg_if.sink   cfg
);

  localparam int unsigned AW = $clog2(RING_SIZE);
  localparam logic [AW-1:0] WP_RST = AW'(RING_SIZE - MAX_STRING);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_COPY
  } state_t;

  state_t               state;
  logic [AW-1:0]        clr_cnt;
  logic                 clr_decode;
  logic [AW-1:0]        wp;
  logic [AW-1:0]        rd_ptr;
  lzrd_pkg::flag_t      flag_shift;
  lzrd_pkg::phase_t     phase;
  lzrd_pkg::byte_t      held_low_byte;
  lzrd_pkg::byte_t      cur_byte;
  lzrd_pkg::byte_t      fill_byte;
  lzrd_pkg::bias_t      length_bias;
  lzrd_pkg::len_t       issue_left;
  lzrd_pkg::len_t       emit_left;
  logic                 rd_pend;
  logic                 fwd_hit;
  lzrd_pkg::byte_t      fwd_data;
  logic                 out_valid;
  lzrd_pkg::byte_t      out_byte;
  logic                 out_last;

  logic                 slot_free;
  logic                 consume;
  logic                 rd_issue;
  logic                 lit_emit;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  lzrd_pkg::byte_t      ram_wdata;
  lzrd_pkg::byte_t      ram_rdata;
  lzrd_pkg::byte_t      cval;
  lzrd_pkg::flag_t      flag_shr;
  lzrd_pkg::len_t       match_len;

  assign compressed.ready     = (state == S_IDLE);
  assign cfg.ready            = 1'b1;
  assign decompressed.valid   = out_valid;
  assign decompressed.out_byte = out_byte;
  assign decompressed.last_of_run = out_last;

  assign slot_free = !out_valid || decompressed.ready;
  assign cval      = fwd_hit ? fwd_data : ram_rdata;
  assign consume   = (state == S_COPY) && rd_pend && slot_free;
  assign rd_issue  = (state == S_COPY) && (issue_left != '0) && (!rd_pend || consume);
  assign lit_emit  = (state == S_DECODE) && (phase == lzrd_pkg::PH_ITEM) &&
                     flag_shift[0] && slot_free;
  assign flag_shr  = flag_shift >> 1;
  assign match_len = lzrd_pkg::len_t'(cur_byte[3:0]) + lzrd_pkg::len_t'(length_bias)
                   + lzrd_pkg::len_t'(1);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wp;
    ram_wdata = cur_byte;
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
      ram_wdata = fill_byte;
    end else if (lit_emit) begin
      ram_we = 1'b1;
    end else if (consume) begin
      ram_we    = 1'b1;
      ram_wdata = cval;
    end
  end

  lzrd_ram #(
    .WIDTH (lzrd_pkg::BYTE_W),
    .DEPTH (RING_SIZE)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (rd_issue),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_cnt       <= '0;
      clr_decode    <= 1'b0;
      wp            <= WP_RST;
      flag_shift    <= '0;
      phase         <= lzrd_pkg::PH_FLAG;
      held_low_byte <= '0;
      fill_byte     <= lzrd_pkg::FILL_BYTE_RST;
      length_bias   <= lzrd_pkg::LENGTH_BIAS_RST;
      issue_left    <= '0;
      emit_left     <= '0;
      rd_pend       <= 1'b0;
      fwd_hit       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          lzrd_pkg::CFG_FILL_BYTE:   fill_byte   <= cfg.data;
          lzrd_pkg::CFG_LENGTH_BIAS: length_bias <= cfg.data[lzrd_pkg::BIAS_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && decompressed.ready && !lit_emit && !consume) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == '1) begin
            state <= clr_decode ? S_DECODE : S_IDLE;
          end
        end

        S_IDLE: begin
          if (compressed.valid) begin
            cur_byte <= compressed.in_byte;
            if (compressed.start_of_stream) begin
              wp            <= WP_RST;
              flag_shift    <= '0;
              phase         <= lzrd_pkg::PH_FLAG;
              held_low_byte <= '0;
              clr_cnt       <= '0;
              clr_decode    <= 1'b1;
              state         <= S_CLEAR;
            end else begin
              state <= S_DECODE;
            end
          end
        end

        S_DECODE: begin
          case (phase)
            lzrd_pkg::PH_ITEM: begin
              if (flag_shift[0]) begin
                if (slot_free) begin
                  out_valid <= 1'b1;
                  out_byte  <= cur_byte;
                  out_last  <= 1'b1;
                  wp        <= wp + AW'(1);
                  phase     <= lzrd_pkg::PH_FLAG;
                  state     <= S_IDLE;
                end
              end else begin
                held_low_byte <= cur_byte;
                phase         <= lzrd_pkg::PH_MATCH;
                state         <= S_IDLE;
              end
            end
            lzrd_pkg::PH_MATCH: begin
              rd_ptr     <= AW'({cur_byte[7:4], held_low_byte});
              issue_left <= match_len;
              emit_left  <= match_len;
              phase      <= lzrd_pkg::PH_FLAG;
              state      <= S_COPY;
            end
            default: begin
              // flag bits exhausted: this byte is a new flag byte; else shift the flags
              if (!flag_shr[8]) begin
                flag_shift <= {lzrd_pkg::FLAG_MARK, cur_byte};
                phase      <= lzrd_pkg::PH_ITEM;
                state      <= S_IDLE;
              end else begin
                flag_shift <= flag_shr;
                phase      <= lzrd_pkg::PH_ITEM;
              end
            end
          endcase
        end

        S_COPY: begin
          if (rd_issue) begin
            rd_ptr     <= rd_ptr + AW'(1);
            issue_left <= issue_left - lzrd_pkg::len_t'(1);
            fwd_hit    <= consume && (wp == rd_ptr);
            fwd_data   <= cval;
            rd_pend    <= 1'b1;
          end else if (consume) begin
            rd_pend <= 1'b0;
          end
          if (consume) begin
            out_valid <= 1'b1;
            out_byte  <= cval;
            out_last  <= (emit_left == lzrd_pkg::len_t'(1));
            wp        <= wp + AW'(1);
            emit_left <= emit_left - lzrd_pkg::len_t'(1);
            if (emit_left == lzrd_pkg::len_t'(1)) begin
              state <= S_IDLE;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  a_pend_in_copy: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (state == S_COPY))
    else $error("read pending outside copy");

  a_copy_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_COPY) |->
      (emit_left == issue_left + lzrd_pkg::len_t'(rd_pend)))
    else $error("copy read and emit counts out of step");

  a_copy_write_emits: assert property (@(posedge clk) disable iff (rst)
    ((state == S_COPY) && ram_we) |=> out_valid)
    else $error("ring written in copy without an output byte");

  a_no_input_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (!compressed.ready && !rd_pend))
    else $error("input or read active during fill pass");

endmodule

`default_nettype wire
